/* sv/mtr_pkg.sv */
// Shared types and constants for the ranged Mersenne Twister generator.
package mtr_pkg;

  localparam int unsigned ShiftDist   = 397;
  localparam logic [31:0] TwistXor    = 32'h9908b0df;
  localparam logic [31:0] TemperB     = 32'h9d2c5680;
  localparam logic [31:0] TemperC     = 32'hefc60000;
  localparam logic [31:0] SeedMul     = 32'd69069;
  localparam logic [31:0] DefaultSeed = 32'd4375;

  typedef enum logic [1:0] {
    CMD_RAW    = 2'd0,
    CMD_RANGED = 2'd1,
    CMD_RESEED = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Classified request handed from front to back.
  typedef struct packed {
    cmd_e        cmd;
    logic        direct;   // result known up front (equal bounds, no-op)
    logic [31:0] base;     // low bound after ordering, or direct result
    logic [31:0] span;
    logic [31:0] mask;
  } job_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* sv/mtr_if.sv */
// Valid/ready channel interfaces for requests and results.
interface mtr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  modport source (output valid, command, range_low, range_high, input ready);
  modport sink   (input valid, command, range_low, range_high, output ready);
endinterface

interface mtr_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

/* sv/mtr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module mtr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* sv/mtr_front.sv */
// Front end: accepts requests, orders bounds, computes span and mask.
module mtr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mtr_req_if.sink       req,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output mtr_pkg::job_t job_o
);
  logic          full_q;
  mtr_pkg::job_t job_q, job_d;
  logic [31:0]   lo, hi, span;
  logic [31:0]   smear;

  assign req.ready = !full_q || job_ready_i;

  always_comb begin
    logic swap;
    swap = req.range_low > req.range_high;
    lo   = swap ? req.range_high : req.range_low;
    hi   = swap ? req.range_low  : req.range_high;
    span = hi - lo;
    smear = span;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    job_d.cmd    = mtr_pkg::cmd_e'(req.command);
    job_d.span   = span;
    job_d.mask   = smear | 32'd1;
    job_d.base   = lo;
    job_d.direct = 1'b0;
    unique case (mtr_pkg::cmd_e'(req.command))
      mtr_pkg::CMD_RANGED: job_d.direct = (span == '0);
      mtr_pkg::CMD_NONE: begin
        job_d.direct = 1'b1;
        job_d.base   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (req.valid && req.ready) begin
      full_q <= 1'b1;
    end else if (job_ready_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) job_q <= job_d;
  end

  assign job_valid_o = full_q;
  assign job_o       = job_q;
endmodule

/* sv/mtr_back.sv */
// Back end: state memory, incremental twist, seeding, tempering, rejection.
module mtr_back #(
  parameter int unsigned StateWords = 624
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   seed_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  mtr_pkg::job_t job_i,
  mtr_rsp_if.source     rsp
);
  localparam int unsigned AW = $clog2(StateWords);
  localparam logic [AW-1:0] Last = AW'(StateWords - 1);

  typedef enum logic [6:0] {
    S_SEED  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD0   = 7'b0000100,
    S_RD1   = 7'b0001000,
    S_RD2   = 7'b0010000,
    S_WB    = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  // Twist is done word by word on demand: word k is rewritten just before it
  // is first read after wrap.
  state_e       st_q, st_d;
  logic [AW-1:0] idx_q, seed_idx_q, addr;
  logic [31:0]  wk_q, wn_q, seed_val_q;
  logic         we;
  logic [AW-1:0] waddr;
  logic [31:0]  wdata, rdata;
  mtr_pkg::job_t job_q;
  logic [31:0]  res_q;      // result of the current job
  logic [31:0]  out_q;
  logic         out_v_q;
  logic         out_load;
  logic         accept, retry;

  mtr_ram #(.Width(32), .Depth(StateWords)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(addr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, int unsigned d);
    logic [AW:0] s;
    s = {1'b0, a} + (AW+1)'(d);
    if (s >= (AW+1)'(StateWords)) s = s - (AW+1)'(StateWords);
    return s[AW-1:0];
  endfunction

  // Next twisted value of word idx_q: needs word idx, idx+1, idx+397.
  logic [31:0] y, tv, word;
  assign y  = {wk_q[31], wn_q[30:0]};
  assign tv = rdata ^ (y >> 1) ^ (y[0] ? mtr_pkg::TwistXor : 32'd0);
  // Before twist of word idx, words idx+1.. of the old table are still old
  // except for wrap: words below idx were twisted already, which matches the
  // sequential in-place update of the model.
  assign word = tv;

  logic [31:0] pick;
  assign pick = mtr_pkg::temper(word) & job_q.mask;

  assign accept = (st_q == S_IDLE) && job_valid_i;
  assign job_ready_o = (st_q == S_IDLE);
  assign retry = (st_q == S_RD2) && job_q.cmd == mtr_pkg::CMD_RANGED
                 && (pick > job_q.span);
  assign out_load = (st_q == S_OUT) && (!out_v_q || rsp.ready);

  always_comb begin
    st_d  = st_q;
    addr  = idx_q;
    we    = 1'b0;
    waddr = idx_q;
    wdata = tv;
    unique case (st_q)
      S_SEED: begin
        we = 1'b1; waddr = seed_idx_q; wdata = seed_val_q;
        if (seed_idx_q == Last) st_d = S_IDLE;
      end
      S_IDLE: if (job_valid_i) begin
        unique case (job_i.cmd)
          mtr_pkg::CMD_RESEED: st_d = S_OUT;
          mtr_pkg::CMD_RAW:    st_d = S_RD0;
          mtr_pkg::CMD_RANGED: st_d = job_i.direct ? S_OUT : S_RD0;
          default:             st_d = S_OUT;
        endcase
        addr = idx_q;
      end
      S_RD0: begin addr = wrap_add(idx_q, 1); st_d = S_RD1; end
      S_RD1: begin addr = wrap_add(idx_q, mtr_pkg::ShiftDist); st_d = S_RD2; end
      S_RD2: begin
        we = 1'b1;
        // a rejected pick starts the next draw at the following word
        if (retry) begin
          addr = wrap_add(idx_q, 1);
          st_d = S_RD0;
        end else begin
          st_d = S_WB;
        end
      end
      S_WB: st_d = S_OUT;
      // reseed answers first, then sweeps the table
      S_OUT: if (!out_v_q || rsp.ready) begin
        st_d = (job_q.cmd == mtr_pkg::CMD_RESEED) ? S_SEED : S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // The twist is always applied at read time; the table holds old words
  // until rewritten, so every read passes through S_RD0..S_RD2.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_SEED;
      seed_idx_q <= '0;
      seed_val_q <= mtr_pkg::DefaultSeed;
      idx_q      <= '0;
      out_v_q    <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) out_v_q <= 1'b1;
      else if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
      if (st_q == S_SEED) begin
        seed_idx_q <= seed_idx_q + AW'(1);
        seed_val_q <= seed_val_q * mtr_pkg::SeedMul;
        if (seed_idx_q == Last) idx_q <= '0;
      end
      if (accept && job_i.cmd == mtr_pkg::CMD_RESEED) begin
        seed_idx_q <= '0;
        seed_val_q <= (seed_i == '0) ? mtr_pkg::DefaultSeed : seed_i;
      end
      if (st_q == S_RD2) begin
        idx_q <= (idx_q == Last) ? '0 : idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_i;
      if (job_i.cmd == mtr_pkg::CMD_RESEED) res_q <= '0;
      else res_q <= job_i.base;
    end
    if (st_q == S_RD0) wk_q <= rdata;
    if (st_q == S_RD1) wn_q <= rdata;
    if (st_q == S_RD2) begin
      res_q <= (job_q.cmd == mtr_pkg::CMD_RAW) ? mtr_pkg::temper(tv)
                                               : pick + job_q.base;
    end
    if (out_load) out_q <= res_q;
  end

  assign rsp.valid = out_v_q;
  assign rsp.value = out_q;
endmodule

/* sv/mersenne_twister_ranged_rng.sv */
// Top level of the ranged Mersenne Twister generator.
//
// Usage: requests arrive on req (valid/ready) with a command and two signed
// bounds; each request yields exactly one result on rsp (valid/ready).
//   raw     - next tempered 32-bit word
//   ranged  - uniform pick in [low, high], bounds in either order
//   reseed  - rebuild the 624-word state from the seed register, result 0
// The seed register is written with seed_we_i/seed_i while idle.
// State words are twisted one at a time when they are consumed, so there is
// no 624-word twist burst; each draw passes S_RD0, S_RD1 and S_RD2 in the back
// end (three reads of the single-read state RAM, write-back on the third).
// A raw request passes S_RD0..S_RD2, S_WB and S_OUT before its result is
// registered; each rejected word of a ranged pick repeats S_RD0..S_RD2 (fewer
// than two draws expected). Equal bounds and the unused command skip to S_OUT.
// Reseed answers from S_OUT, then sweeps the RAM one word a cycle; reset
// sweeps likewise. During a sweep no request reaches the back end.
// A front register takes the next request while the back end works; the
// output register holds a result until rsp.ready, and the back end stalls
// once a second result is ready behind it.
module mersenne_twister_ranged_rng #(
  parameter int unsigned StateWords = 624
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  mtr_req_if.sink     req,
  mtr_rsp_if.source   rsp
);
  logic [31:0]   seed_q;
  logic          job_valid, job_ready;
  mtr_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= mtr_pkg::DefaultSeed;
    else if (seed_we_i) seed_q <= seed_i;
  end

  mtr_front u_front (
    .clk_i, .rst_ni, .req,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  mtr_back #(.StateWords(StateWords)) u_back (
    .clk_i, .rst_ni, .seed_i(seed_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job), .rsp
  );
endmodule

/* tb/tb_mersenne_twister_ranged_rng.sv */
// Self-checking testbench for the ranged Mersenne Twister generator.
module tb_mersenne_twister_ranged_rng;

  localparam int unsigned NumWords    = 624;
  localparam int unsigned FarDist     = 397;
  localparam int unsigned SweepCycles = 700;     // reseed/reset RAM sweep plus margin
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned PhaseItems  = 210;
  localparam int unsigned NumPhases   = 5;
  localparam logic [31:0] MinInt      = 32'h80000000;
  localparam logic [31:0] MaxInt      = 32'h7fffffff;

  logic        clk;
  logic        rst_n;
  logic        seed_we;
  logic [31:0] seed_val;

  mtr_req_if req_ch ();
  mtr_rsp_if rsp_ch ();

  mersenne_twister_ranged_rng u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .seed_we_i (seed_we),
    .seed_i    (seed_val),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Predictor state: its own copy of the generator and the seed register.
  logic [31:0] gen_words [NumWords];
  int unsigned gen_index;
  logic [31:0] seed_reg;

  logic [31:0] expected_values [$];
  int unsigned error_count;
  int unsigned cycle_count = 0;
  bit          sender_burst;
  bit          receiver_burst;

  // Directed stimulus row; has_value marks a result that is known up front.
  typedef struct {
    mtr_pkg::cmd_e cmd;
    logic [31:0]   lo;
    logic [31:0]   hi;
    bit            has_value;
    logic [31:0]   value;
  } stim_row_t;

  function automatic void gen_load(input logic [31:0] s);
    if (s == 32'd0) s = mtr_pkg::DefaultSeed;
    gen_words[0] = s;
    for (int unsigned i = 1; i < NumWords; i++)
      gen_words[i] = mtr_pkg::SeedMul * gen_words[i-1];
    gen_index = NumWords;
  endfunction

  function automatic void gen_twist();
    logic [31:0] y;
    logic [31:0] v;
    for (int unsigned k = 0; k < NumWords; k++) begin
      y = (gen_words[k] & 32'h80000000) | (gen_words[(k + 1) % NumWords] & 32'h7fffffff);
      v = gen_words[(k + FarDist) % NumWords] ^ (y >> 1);
      if (y[0]) v = v ^ mtr_pkg::TwistXor;
      gen_words[k] = v;
    end
    gen_index = 0;
  endfunction

  function automatic logic [31:0] gen_draw();
    logic [31:0] y;
    if (gen_index >= NumWords) gen_twist();
    y = gen_words[gen_index];
    gen_index++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtr_pkg::TemperB);
    y = y ^ ((y << 15) & mtr_pkg::TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] gen_ranged(input logic [31:0] lo, input logic [31:0] hi);
    logic [31:0] span;
    logic [31:0] mask;
    logic [31:0] pick;
    logic [31:0] t;
    int          bitpos;
    if (lo == hi) return lo;
    if ($signed(lo) > $signed(hi)) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    span   = hi - lo;   // unsigned span covers the full signed range
    bitpos = 31;
    while (bitpos > 0 && !span[bitpos]) bitpos--;
    mask = (bitpos >= 31) ? 32'hffffffff : ((32'd1 << (bitpos + 1)) - 32'd1);
    do begin
      pick = gen_draw() & mask;
    end while (pick > span);
    return pick + lo;
  endfunction

  function automatic logic [31:0] gen_predict(input mtr_pkg::cmd_e cmd,
                                             input logic [31:0] lo,
                                             input logic [31:0] hi);
    logic [31:0] v;
    v = 32'd0;
    case (cmd)
      mtr_pkg::CMD_RAW:    v = gen_draw();
      mtr_pkg::CMD_RANGED: v = gen_ranged(lo, hi);
      mtr_pkg::CMD_RESEED: gen_load(seed_reg);
      default:             v = 32'd0;   // unused command leaves state alone
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycle_count);
    error_count++;
  endtask

  // Clock and cycle-limit watchdog.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall per result, with stretches of none.
  initial begin
    int unsigned stall;
    int unsigned taken;
    logic [31:0] want;
    rsp_ch.ready   = 1'b0;
    receiver_burst = 1'b0;
    taken          = 0;
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      stall = receiver_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      taken++;
      if (expected_values.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, rsp_ch.value);
      end else begin
        want = expected_values.pop_front();
        if (rsp_ch.value !== want) report_mismatch("value", want, rsp_ch.value);
      end
    end
  end

  // Send one request after a random gap; prediction made at acceptance.
  task automatic send_request(input mtr_pkg::cmd_e cmd, input logic [31:0] lo,
                              input logic [31:0] hi,
                              input bit has_value, input logic [31:0] value);
    int unsigned gap;
    logic [31:0] predicted;
    gap = sender_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    predicted = gen_predict(cmd, lo, hi);
    if (has_value && predicted !== value) report_mismatch("predictor", value, predicted);
    expected_values.push_back(has_value ? value : predicted);
  endtask

  // Hold off until all results are back and any sweep has finished.
  task automatic drain_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (SweepCycles) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] s);
    seed_we  <= 1'b1;
    seed_val <= s;
    @(posedge clk);
    seed_we  <= 1'b0;
    seed_reg = s;
    @(posedge clk);
  endtask

  task automatic send_random();
    mtr_pkg::cmd_e cmd;
    logic [31:0]   lo;
    logic [31:0]   hi;
    int unsigned   sel;
    lo  = $urandom();
    hi  = $urandom();
    sel = $urandom_range(0, 99);
    if (sel < 40)      cmd = mtr_pkg::CMD_RAW;
    else if (sel < 90) cmd = mtr_pkg::CMD_RANGED;
    else if (sel < 95) cmd = mtr_pkg::CMD_RESEED;
    else               cmd = mtr_pkg::CMD_NONE;
    if (cmd == mtr_pkg::CMD_RANGED) begin
      sel = $urandom_range(0, 9);
      // Narrow spans most often; some equal, some with a span at or one below a power of 2, some wide.
      if (sel < 4)      hi = lo + $urandom_range(1, 20);
      else if (sel < 5) hi = lo;
      else if (sel < 7) hi = lo + (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      if ($urandom_range(0, 1)) {lo, hi} = {hi, lo};
    end
    send_request(cmd, lo, hi, 1'b0, 32'd0);
  endtask

  initial begin
    stim_row_t   rows [$];
    logic [31:0] phase_seeds [NumPhases];
    error_count    = 0;
    sender_burst   = 1'b0;
    rst_n          = 1'b0;
    seed_we        = 1'b0;
    seed_val       = 32'd0;
    req_ch.valid   = 1'b0;
    req_ch.command = mtr_pkg::CMD_NONE;
    req_ch.range_low  = 32'd0;
    req_ch.range_high = 32'd0;
    seed_reg = mtr_pkg::DefaultSeed;
    gen_load(mtr_pkg::DefaultSeed);

    rows = '{
      '{mtr_pkg::CMD_RAW,    32'd0,    32'd0,        1'b0, 32'd0},
      '{mtr_pkg::CMD_RAW,    32'hffffffff, 32'hffffffff, 1'b0, 32'd0},
      '{mtr_pkg::CMD_RANGED, 32'd5,    32'd5,        1'b1, 32'd5},        // equal bounds
      '{mtr_pkg::CMD_RANGED, MinInt,   MinInt,       1'b1, MinInt},
      '{mtr_pkg::CMD_RANGED, MaxInt,   MaxInt,       1'b1, MaxInt},
      '{mtr_pkg::CMD_RANGED, 32'd0,    32'd9,        1'b0, 32'd0},
      '{mtr_pkg::CMD_RANGED, 32'd9,    32'd0,        1'b0, 32'd0},        // swapped bounds
      '{mtr_pkg::CMD_RANGED, MinInt,   MaxInt,       1'b0, 32'd0},        // full span
      '{mtr_pkg::CMD_RANGED, MaxInt,   MinInt,       1'b0, 32'd0},
      '{mtr_pkg::CMD_RANGED, 32'hffffffff, 32'd0,    1'b0, 32'd0},
      '{mtr_pkg::CMD_RANGED, 32'd0,    32'd2,        1'b0, 32'd0},        // rejection (pick 3 exceeds span)
      '{mtr_pkg::CMD_RANGED, 32'hffffff9c, 32'd100,  1'b0, 32'd0},
      '{mtr_pkg::CMD_RANGED, 32'd0,    32'h40000000, 1'b0, 32'd0},
      '{mtr_pkg::CMD_NONE,   32'hffffffff, 32'h12345678, 1'b1, 32'd0},    // unused command
      '{mtr_pkg::CMD_RESEED, 32'd0,    32'd0,        1'b1, 32'd0},        // zero seed falls back
      '{mtr_pkg::CMD_RAW,    32'd0,    32'd0,        1'b0, 32'd0},
      '{mtr_pkg::CMD_RANGED, 32'd1,    32'd0,        1'b0, 32'd0},
      '{mtr_pkg::CMD_NONE,   32'd0,    32'd0,        1'b1, 32'd0},
      '{mtr_pkg::CMD_RAW,    32'd0,    32'd0,        1'b0, 32'd0},
      '{mtr_pkg::CMD_RESEED, 32'hffffffff, 32'hffffffff, 1'b1, 32'd0},
      '{mtr_pkg::CMD_RANGED, MinInt,   32'd0,        1'b0, 32'd0}
    };
    phase_seeds = '{32'hffffffff, $urandom(), 32'd1, 32'd0, 32'h80000000};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_seed(32'd0);

    foreach (rows[i]) send_request(rows[i].cmd, rows[i].lo, rows[i].hi,
                                   rows[i].has_value, rows[i].value);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain_idle();
      write_seed(phase_seeds[p]);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) sender_burst = ($urandom_range(0, 3) == 0);
        send_random();
      end
    end

    drain_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
